// File: hw/rtl/rse_pkg.sv
`default_nettype none
package rse_pkg;

  localparam int DATA_WORDS = 64;
  localparam int DMEM_AW    = (DATA_WORDS > 1) ? $clog2(DATA_WORDS) : 1;
  localparam int XLEN       = 32;
  localparam int PC_W       = 28;
  localparam int RF_AW      = 5;
  localparam int RF_DEPTH   = 32;
  localparam int MIDX_W     = 6;
  localparam int PADDR_W    = 3;

  // register map
  localparam logic REG_DATA_BASE = 1'b0;

  // item kinds
  localparam logic KIND_EXEC    = 1'b0;
  localparam logic KIND_PRELOAD = 1'b1;

  // instruction categories
  localparam logic [1:0] CAT_CTRL = 2'b00;
  localparam logic [1:0] CAT_REG  = 2'b01;
  localparam logic [1:0] CAT_IMM  = 2'b10;

  // control category opcodes
  localparam logic [3:0] OP_J     = 4'b0000;
  localparam logic [3:0] OP_BEQ   = 4'b0010;
  localparam logic [3:0] OP_BGTZ  = 4'b0100;
  localparam logic [3:0] OP_BREAK = 4'b0101;
  localparam logic [3:0] OP_SW    = 4'b0110;
  localparam logic [3:0] OP_LW    = 4'b0111;

  // register category opcodes
  localparam logic [3:0] ALU_ADD = 4'd0;
  localparam logic [3:0] ALU_SUB = 4'd1;
  localparam logic [3:0] ALU_MUL = 4'd2;
  localparam logic [3:0] ALU_AND = 4'd3;
  localparam logic [3:0] ALU_OR  = 4'd4;
  localparam logic [3:0] ALU_XOR = 4'd5;
  localparam logic [3:0] ALU_NOR = 4'd6;

  // immediate category opcodes
  localparam logic [3:0] IMM_ADDI = 4'd0;
  localparam logic [3:0] IMM_ANDI = 4'd1;
  localparam logic [3:0] IMM_ORI  = 4'd2;
  localparam logic [3:0] IMM_XORI = 4'd3;

  typedef struct packed {
    logic [PC_W-1:0]    next_pc;
    logic               halted;
    logic               set_stop;
    logic               reg_we;
    logic [RF_AW-1:0]   reg_num;
    logic [XLEN-1:0]    reg_val;
    logic               is_load;
    logic               mem_we;
    logic [DMEM_AW-1:0] mem_idx;
    logic [XLEN-1:0]    mem_val;
    logic               fault;
  } exec_res_t;

  function automatic logic [XLEN-1:0] sext16(input logic [15:0] v);
    return {{(XLEN-16){v[15]}}, v};
  endfunction

  // first source register, placed by category
  function automatic logic [RF_AW-1:0] src_a(input logic [XLEN-1:0] w);
    return (w[31:30] == CAT_CTRL) ? w[25:21] : w[29:25];
  endfunction

  function automatic logic [RF_AW-1:0] src_b(input logic [XLEN-1:0] w);
    return (w[31:30] == CAT_CTRL) ? w[20:16] : w[24:20];
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/rse_regfile.sv
`default_nettype none
module rse_regfile (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      rd_en,
  input  wire logic [rse_pkg::RF_AW-1:0] rd_addr_a,
  input  wire logic [rse_pkg::RF_AW-1:0] rd_addr_b,
  output logic      [rse_pkg::XLEN-1:0]  rd_data_a,
  output logic      [rse_pkg::XLEN-1:0]  rd_data_b,
  input  wire logic                      wr_en,
  input  wire logic [rse_pkg::RF_AW-1:0] wr_addr,
  input  wire logic [rse_pkg::XLEN-1:0]  wr_data
);
  import rse_pkg::*;

  logic [XLEN-1:0]     mem [RF_DEPTH];
  logic [RF_DEPTH-1:0] vld;
  logic [XLEN-1:0]     data_a;
  logic [XLEN-1:0]     data_b;
  logic                vld_a;
  logic                vld_b;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      data_a <= mem[rd_addr_a];
      data_b <= mem[rd_addr_b];
    end
  end

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      vld_a <= 1'b0;
      vld_b <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        vld_a <= vld[rd_addr_a];
        vld_b <= vld[rd_addr_b];
      end
    end
  end

  assign rd_data_a = vld_a ? data_a : '0;
  assign rd_data_b = vld_b ? data_b : '0;

endmodule
`default_nettype wire

// File: hw/rtl/rse_dmem.sv
`default_nettype none
module rse_dmem (
  input  wire logic                        clk,
  input  wire logic                        wr_en,
  input  wire logic                        rd_en,
  input  wire logic [rse_pkg::DMEM_AW-1:0] addr,
  input  wire logic [rse_pkg::XLEN-1:0]    wr_data,
  output logic      [rse_pkg::XLEN-1:0]    rd_data
);
  import rse_pkg::*;

  logic [XLEN-1:0] mem [DATA_WORDS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wr_data;
    end else if (rd_en) begin
      rd_data <= mem[addr];
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/rse_exec.sv
`default_nettype none
module rse_exec (
  input  wire logic                       kind,
  input  wire logic [rse_pkg::PC_W-1:0]   pc,
  input  wire logic [rse_pkg::XLEN-1:0]   instr,
  input  wire logic [rse_pkg::MIDX_W-1:0] pidx,
  input  wire logic [rse_pkg::XLEN-1:0]   a,
  input  wire logic [rse_pkg::XLEN-1:0]   b,
  input  wire logic                       stopped,
  input  wire logic [rse_pkg::PC_W-1:0]   data_base,
  output rse_pkg::exec_res_t              res
);
  import rse_pkg::*;

  logic [1:0]      cat;
  logic [3:0]      op_ctrl;
  logic [3:0]      op_alu;
  logic [XLEN-1:0] off;
  logic [PC_W-1:0] br_target;
  logic [XLEN-1:0] mem_addr;
  logic [XLEN-1:0] word_idx;
  logic            mem_fault;
  logic [XLEN-1:0] imm_z;

  assign cat       = instr[31:30];
  assign op_ctrl   = instr[29:26];
  assign op_alu    = instr[19:16];
  assign off       = sext16(instr[15:0]);
  assign imm_z     = {{(XLEN-16){1'b0}}, instr[15:0]};
  assign br_target = pc + PC_W'(4) + {off[PC_W-3:0], 2'b00};
  // base + offset - data_base in one three-input add
  assign mem_addr  = a + off - {{(XLEN-PC_W){1'b0}}, data_base};
  assign word_idx  = mem_addr >> 2;
  assign mem_fault = word_idx >= XLEN'(DATA_WORDS);

  always_comb begin
    res         = '0;
    res.next_pc = pc + PC_W'(4);
    res.halted  = stopped;
    if (kind == KIND_PRELOAD) begin
      res.next_pc = pc;
      if (XLEN'(pidx) < XLEN'(DATA_WORDS)) begin
        res.mem_we  = 1'b1;
        res.mem_idx = DMEM_AW'(pidx);
        res.mem_val = instr;
      end else begin
        res.fault = 1'b1;
      end
    end else if (stopped) begin
      res.next_pc = pc;
    end else begin
      case (cat)
        CAT_CTRL: begin
          case (op_ctrl)
            OP_J: begin
              res.next_pc = {instr[PC_W-3:0], 2'b00};
            end
            OP_BEQ: begin
              if (a == b) begin
                res.next_pc = br_target;
              end
            end
            OP_BGTZ: begin
              if (a != '0 && !a[XLEN-1]) begin
                res.next_pc = br_target;
              end
            end
            OP_BREAK: begin
              res.set_stop = 1'b1;
              res.halted   = 1'b1;
              res.next_pc  = pc;
            end
            OP_SW: begin
              res.mem_idx = DMEM_AW'(word_idx);
              if (mem_fault) begin
                res.fault = 1'b1;
              end else begin
                res.mem_we  = 1'b1;
                res.mem_val = b;
              end
            end
            OP_LW: begin
              res.mem_idx = DMEM_AW'(word_idx);
              res.reg_num = instr[20:16];
              if (mem_fault) begin
                res.fault = 1'b1;
              end else begin
                res.is_load = 1'b1;
                res.reg_we  = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
        CAT_REG: begin
          res.reg_num = instr[15:11];
          res.reg_we  = 1'b1;
          case (op_alu)
            ALU_ADD: res.reg_val = a + b;
            ALU_SUB: res.reg_val = a - b;
            ALU_MUL: res.reg_val = a * b;
            ALU_AND: res.reg_val = a & b;
            ALU_OR:  res.reg_val = a | b;
            ALU_XOR: res.reg_val = a ^ b;
            ALU_NOR: res.reg_val = ~(a | b);
            default: begin
              res.reg_we  = 1'b0;
              res.reg_num = '0;
            end
          endcase
        end
        CAT_IMM: begin
          res.reg_num = instr[24:20];
          res.reg_we  = 1'b1;
          case (op_alu)
            IMM_ADDI: res.reg_val = a + off;
            IMM_ANDI: res.reg_val = a & imm_z;
            IMM_ORI:  res.reg_val = a | imm_z;
            IMM_XORI: res.reg_val = a ^ imm_z;
            default: begin
              res.reg_we  = 1'b0;
              res.reg_num = '0;
            end
          endcase
        end
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/risc_subset_execute_step_unit.sv
`default_nettype none
// channel  | direction | handshake                  | payload
// ---------+-----------+----------------------------+---------------------------------------
// item     | in        | item_valid / item_stall    | item_kind pc instr_word preload_index
// result   | out       | result_valid / result_stall| next_pc halted reg_* mem_* addr_fault
// config   | in        | APB psel/penable/pready    | data_base at byte address 0
//
// One beat per cycle sustained while results are not stalled; an item taken passes through
// register read, execute with data memory access, and write back into the output register.
// The register file and data memory are synchronous-read RAMs; the two newest
// register writes are forwarded into execute, so dependent items need no bubble.
// All three stages advance together; a stalled result holds the whole pipe and
// raises item_stall. Reset clears stage valids, register valid bits and the halt flag.
module risc_subset_execute_step_unit (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         item_valid,
  output logic                              item_stall,
  input  wire logic                         item_kind,
  input  wire logic [rse_pkg::PC_W-1:0]     pc,
  input  wire logic [rse_pkg::XLEN-1:0]     instr_word,
  input  wire logic [rse_pkg::MIDX_W-1:0]   preload_index,
  output logic                              result_valid,
  input  wire logic                         result_stall,
  output logic      [rse_pkg::PC_W-1:0]     next_pc,
  output logic                              halted,
  output logic                              reg_written,
  output logic      [rse_pkg::RF_AW-1:0]    reg_number,
  output logic signed [rse_pkg::XLEN-1:0]   reg_value,
  output logic                              mem_written,
  output logic      [rse_pkg::MIDX_W-1:0]   mem_word_index,
  output logic signed [rse_pkg::XLEN-1:0]   mem_value,
  output logic                              addr_fault,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [rse_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [31:0]                  pwdata,
  output logic      [31:0]                  prdata,
  output logic                              pready
);
  import rse_pkg::*;

  logic            advance;
  logic [PC_W-1:0] data_base;
  logic            stopped;

  // read stage
  logic              s1_v;
  logic              s1_kind;
  logic [PC_W-1:0]   s1_pc;
  logic [XLEN-1:0]   s1_instr;
  logic [MIDX_W-1:0] s1_pidx;
  logic              fwd_v;
  logic [RF_AW-1:0]  fwd_addr;
  logic [XLEN-1:0]   fwd_data;
  logic [XLEN-1:0]   rf_a;
  logic [XLEN-1:0]   rf_b;
  logic [RF_AW-1:0]  s1_ra;
  logic [RF_AW-1:0]  s1_rb;
  logic [XLEN-1:0]   op_a;
  logic [XLEN-1:0]   op_b;
  exec_res_t         res;

  // execute / memory stage
  logic            s2_v;
  exec_res_t       s2;
  logic [XLEN-1:0] dmem_q;
  logic [XLEN-1:0] s2_wval;
  logic            s2_wr;

  assign advance    = !result_valid || !result_stall;
  assign item_stall = !advance;
  assign pready     = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      data_base <= '0;
    end else if (psel && penable && pwrite && paddr[2] == REG_DATA_BASE) begin
      data_base <= pwdata[PC_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_DATA_BASE) ? {{(32-PC_W){1'b0}}, data_base} : '0;

  rse_regfile u_rf (
    .clk       (clk),
    .rst       (rst),
    .rd_en     (advance),
    .rd_addr_a (src_a(instr_word)),
    .rd_addr_b (src_b(instr_word)),
    .rd_data_a (rf_a),
    .rd_data_b (rf_b),
    .wr_en     (advance && s2_wr),
    .wr_addr   (s2.reg_num),
    .wr_data   (s2_wval)
  );

  assign s1_ra = src_a(s1_instr);
  assign s1_rb = src_b(s1_instr);

  // newest first: item in stage two, then the write retired as this item was read
  always_comb begin
    if (s2_wr && s2.reg_num == s1_ra) begin
      op_a = s2_wval;
    end else if (fwd_v && fwd_addr == s1_ra) begin
      op_a = fwd_data;
    end else begin
      op_a = rf_a;
    end
    if (s2_wr && s2.reg_num == s1_rb) begin
      op_b = s2_wval;
    end else if (fwd_v && fwd_addr == s1_rb) begin
      op_b = fwd_data;
    end else begin
      op_b = rf_b;
    end
  end

  rse_exec u_exec (
    .kind      (s1_kind),
    .pc        (s1_pc),
    .instr     (s1_instr),
    .pidx      (s1_pidx),
    .a         (op_a),
    .b         (op_b),
    .stopped   (stopped),
    .data_base (data_base),
    .res       (res)
  );

  rse_dmem u_dmem (
    .clk     (clk),
    .wr_en   (advance && s1_v && res.mem_we),
    .rd_en   (advance && s1_v && res.is_load),
    .addr    (res.mem_idx),
    .wr_data (res.mem_val),
    .rd_data (dmem_q)
  );

  assign s2_wr   = s2_v && s2.reg_we;
  assign s2_wval = s2.is_load ? dmem_q : s2.reg_val;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v         <= 1'b0;
      s2_v         <= 1'b0;
      result_valid <= 1'b0;
      fwd_v        <= 1'b0;
      stopped      <= 1'b0;
    end else if (advance) begin
      s1_v         <= item_valid;
      s2_v         <= s1_v;
      result_valid <= s2_v;
      fwd_v        <= s2_wr;
      if (s1_v && res.set_stop) begin
        stopped <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_kind        <= item_kind;
      s1_pc          <= pc;
      s1_instr       <= instr_word;
      s1_pidx        <= preload_index;
      fwd_addr       <= s2.reg_num;
      fwd_data       <= s2_wval;
      s2             <= res;
      next_pc        <= s2.next_pc;
      halted         <= s2.halted;
      reg_written    <= s2.reg_we;
      reg_number     <= s2.reg_we ? s2.reg_num : '0;
      reg_value      <= s2.reg_we ? s2_wval : '0;
      mem_written    <= s2.mem_we;
      mem_word_index <= s2.mem_we ? MIDX_W'(s2.mem_idx) : '0;
      mem_value      <= s2.mem_we ? s2.mem_val : '0;
      addr_fault     <= s2.fault;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/rse_checker.sv
`default_nettype none
module rse_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        item_stall,
  input wire logic                        result_valid,
  input wire logic                        result_stall,
  input wire logic                        halted,
  input wire logic                        reg_written,
  input wire logic [rse_pkg::RF_AW-1:0]   reg_number,
  input wire logic [rse_pkg::XLEN-1:0]    reg_value,
  input wire logic                        mem_written,
  input wire logic                        addr_fault
);
  import rse_pkg::*;

  logic seen_halt;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_halt <= 1'b0;
    end else if (result_valid && !result_stall && halted) begin
      seen_halt <= 1'b1;
    end
  end

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result beat dropped while stalled");

  a_halt_sticks: assert property (@(posedge clk) disable iff (rst)
    result_valid && seen_halt |-> halted)
    else $error("halt flag cleared after a halted beat");

  a_no_input_stall: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> !item_stall)
    else $error("input stalled with empty output");

  a_quiet_reg: assert property (@(posedge clk) disable iff (rst)
    result_valid && !reg_written |-> reg_number == '0 && reg_value == '0)
    else $error("register fields not zero without a write");

  a_fault_suppress: assert property (@(posedge clk) disable iff (rst)
    result_valid && addr_fault |-> !mem_written && !reg_written)
    else $error("access performed despite address fault");

endmodule

bind risc_subset_execute_step_unit rse_checker u_rse_checker (.*);
`default_nettype wire
